/* hdl/hs_pkg.sv */
// ----------------------------------------------------------------------------
// hs_pkg
// Shared types and constants of the heap sort core: default sizes, the
// controller state and the control bundle handed to every sorting cell.
// ----------------------------------------------------------------------------
package hs_pkg;

   localparam int HS_DEPTH       = 64;  // values held per batch
   localparam int HS_VALUE_WIDTH = 32;  // bits kept of each value
   localparam int HS_DATA_WIDTH  = 32;  // width of the value fields on the channels

   typedef enum logic {
      HS_LOAD,
      HS_DRAIN
   } hs_state_type;

   // Control handed from the controller to every cell of the chain
   typedef struct packed {
      logic insert;  // place the incoming value in order
      logic drain;   // move every value one cell towards the head
   } hs_cell_ctl_type;

endpackage

/* hdl/hs_req_if.sv */
// ----------------------------------------------------------------------------
// hs_req_if
// Input channel of the heap sort core: one value of a batch per transaction.
// ----------------------------------------------------------------------------
interface hs_req_if import hs_pkg::*; ();

   logic                            valid;
   logic                            ready;
   logic signed [HS_DATA_WIDTH-1:0] item_value;
   logic                            item_last;

   modport source (output valid, output item_value, output item_last, input ready);
   modport sink   (input valid, input item_value, input item_last, output ready);

endinterface

/* hdl/hs_rsp_if.sv */
// ----------------------------------------------------------------------------
// hs_rsp_if
// Result channel of the heap sort core: one sorted value per transaction.
// ----------------------------------------------------------------------------
interface hs_rsp_if import hs_pkg::*; ();

   logic                            valid;
   logic                            ready;
   logic signed [HS_DATA_WIDTH-1:0] sorted_value;
   logic                            sorted_last;
   logic                            dropped;

   modport source (output valid, output sorted_value, output sorted_last, output dropped,
                   input ready);
   modport sink   (input valid, input sorted_value, input sorted_last, input dropped,
                   output ready);

endinterface

/* hdl/heap_sort_core.sv */
// ----------------------------------------------------------------------------
// heap_sort_core
// Batch sorter: values of a batch are kept in ascending order in a chain of
// cells as they arrive, then streamed out smallest first.
//
//   channel   dir  transaction carries
//   req_if    in   item_value, item_last
//   rsp_if    out  sorted_value, sorted_last, dropped
//
// Each value is taken as it arrives; every cell compares it with its own
// value and the chain shifts to open its slot. After the last value the
// results follow one per cycle from the head cell, the first in the next
// cycle. No values are taken while a batch drains. Reset empties the chain
// at once. A stalled result holds in the head cell.
// ----------------------------------------------------------------------------
module heap_sort_core import hs_pkg::*; #(
   parameter int DEPTH       = HS_DEPTH,
   parameter int VALUE_WIDTH = HS_VALUE_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   hs_req_if.sink      req_if,
   hs_rsp_if.source    rsp_if
);

   hs_cell_ctl_type               ctl;
   logic signed [VALUE_WIDTH-1:0] ins_value;
   logic signed [VALUE_WIDTH-1:0] cell_value [DEPTH];
   logic                          cell_valid [DEPTH];
   logic                          cell_lt    [DEPTH];

   // Take the low bits of the value, or widen it by its sign
   generate
      if (VALUE_WIDTH <= HS_DATA_WIDTH) begin : g_in_narrow
         assign ins_value = req_if.item_value[VALUE_WIDTH-1:0];
         if (VALUE_WIDTH < HS_DATA_WIDTH) begin : g_out_ext
            assign rsp_if.sorted_value = HS_DATA_WIDTH'(cell_value[0]);
         end else begin : g_out_same
            assign rsp_if.sorted_value = cell_value[0];
         end
      end else begin : g_in_wide
         assign ins_value = VALUE_WIDTH'(req_if.item_value);
         assign rsp_if.sorted_value = cell_value[0][HS_DATA_WIDTH-1:0];
      end
   endgenerate

   hs_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_last    (req_if.item_last),
      .req_ready   (req_if.ready),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_last    (rsp_if.sorted_last),
      .rsp_dropped (rsp_if.dropped),
      .ctl         (ctl)
   );

   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         logic signed [VALUE_WIDTH-1:0] left_value, right_value;
         logic                          left_valid, left_lt, right_valid;

         if (i == 0) begin : g_head
            assign left_value = '0;
            assign left_valid = 1'b0;
            assign left_lt    = 1'b0;
         end else begin : g_mid
            assign left_value = cell_value[i-1];
            assign left_valid = cell_valid[i-1];
            assign left_lt    = cell_lt[i-1];
         end

         if (i == DEPTH - 1) begin : g_tail
            assign right_value = '0;
            assign right_valid = 1'b0;
         end else begin : g_body
            assign right_value = cell_value[i+1];
            assign right_valid = cell_valid[i+1];
         end

         hs_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .ins_value   (ins_value),
            .left_value  (left_value),
            .left_valid  (left_valid),
            .left_lt     (left_lt),
            .right_value (right_value),
            .right_valid (right_valid),
            .value       (cell_value[i]),
            .valid       (cell_valid[i]),
            .lt          (cell_lt[i])
         );
      end
   endgenerate

endmodule

/* hdl/hs_cell.sv */
// ----------------------------------------------------------------------------
// hs_cell
// One slot of the sorting chain. The chain keeps its values in ascending
// order from the head; an empty slot counts as larger than any value.
// ----------------------------------------------------------------------------
module hs_cell import hs_pkg::*; #(
   parameter int VALUE_WIDTH = HS_VALUE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hs_cell_ctl_type               ctl,
   input  logic signed [VALUE_WIDTH-1:0] ins_value,
   input  logic signed [VALUE_WIDTH-1:0] left_value,
   input  logic                          left_valid,
   input  logic                          left_lt,
   input  logic signed [VALUE_WIDTH-1:0] right_value,
   input  logic                          right_valid,
   output logic signed [VALUE_WIDTH-1:0] value,
   output logic                          valid,
   output logic                          lt
);

   logic signed [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                          valid_ff, valid_in;

   // Incoming value belongs before this slot
   assign lt = !valid_ff || (ins_value < value_ff);

   always_comb begin
      priority if (ctl.drain) begin
         value_in = right_value;
         valid_in = right_valid;
      end else if (ctl.insert && left_lt) begin
         // shift up to make room further towards the head
         value_in = left_value;
         valid_in = left_valid;
      end else if (ctl.insert && lt) begin
         value_in = ins_value;
         valid_in = 1'b1;
      end else begin
         value_in = value_ff;
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

/* hdl/hs_ctrl.sv */
// ----------------------------------------------------------------------------
// hs_ctrl
// Batch controller: counts stored values, notes overflow, and sequences the
// load and drain phases of the sorting chain.
// ----------------------------------------------------------------------------
module hs_ctrl import hs_pkg::*; #(
   parameter int DEPTH = HS_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_last,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic            rsp_last,
   output logic            rsp_dropped,
   output hs_cell_ctl_type ctl
);

   localparam int CntW = $clog2(DEPTH + 1);

   hs_state_type   state_ff, state_in;
   logic [CntW-1:0] fill_ff, fill_in;
   logic            ovf_ff, ovf_in;
   logic            req_take, rsp_take, room;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HS_LOAD;
         fill_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign room = (fill_ff != CntW'(DEPTH));

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      ovf_in      = ovf_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      req_take    = 1'b0;
      rsp_take    = 1'b0;
      ctl.insert  = 1'b0;
      ctl.drain   = 1'b0;
      unique case (state_ff)
         HS_LOAD: begin
            req_ready = 1'b1;
            req_take  = req_valid;
            if (req_take) begin
               if (room) begin
                  ctl.insert = 1'b1;
                  fill_in    = fill_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  state_in = HS_DRAIN;
               end
            end
         end
         HS_DRAIN: begin
            rsp_valid = 1'b1;
            rsp_take  = rsp_ready;
            if (rsp_take) begin
               ctl.drain = 1'b1;
               fill_in   = fill_ff - 1'b1;
               if (rsp_last) begin
                  // batch done: start the next one empty
                  ovf_in   = 1'b0;
                  state_in = HS_LOAD;
               end
            end
         end
         default: begin
            state_in = HS_LOAD;
         end
      endcase
   end

   assign rsp_last    = (fill_ff == CntW'(1));
   assign rsp_dropped = ovf_ff;

endmodule
